/* src/edc_pkg.sv */
package edc_pkg;

    // Fixed-point format and saturation width
    localparam int FRAC = 16;
    localparam int WORD = 32;

    // Queue between the classifier and the solver
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    // Solver stage map
    localparam int NSQ  = 32;
    localparam int NDV  = FRAC + 1;
    localparam int NQD  = 35;
    localparam int S_DV = NSQ;
    localparam int S_M1 = S_DV + NDV;
    localparam int S_M2 = S_M1 + 1;
    localparam int S_P1 = S_M2 + 1;
    localparam int S_P2 = S_P1 + 1;
    localparam int S_QD = S_P2 + 1;
    localparam int S_AD = S_QD + NQD;
    localparam int S_F1 = S_AD + 1;
    localparam int NST  = S_F1 + 1;

    typedef logic signed [31:0] sfield_t;
    typedef logic [30:0]        ufield_t;
    typedef logic signed [63:0] wide_t;

    typedef struct packed {
        sfield_t pos_x;
        sfield_t pos_y;
        sfield_t vel_x;
        sfield_t vel_y;
        ufield_t radius;
        ufield_t mass;
    } disc_t;

    // Classified request as it leaves the front end
    typedef struct packed {
        disc_t       a;
        disc_t       b;
        logic        hit;
        logic [63:0] dist2;
        logic [31:0] md;
        logic [31:0] adx;
        logic [31:0] ady;
        logic        dx_neg;
        logic        dy_neg;
    } pair_t;

    // Working context carried down the solver pipeline
    typedef struct packed {
        pair_t              p;
        logic [63:0]        srem;
        logic [63:0]        sres;
        logic [31:0]        d;
        logic [FRAC+31:0]   xrem;
        logic [FRAC+31:0]   yrem;
        logic [FRAC:0]      nxq;
        logic [FRAC:0]      nyq;
        logic [FRAC+32:0]   hx;
        logic [FRAC+32:0]   hy;
        wide_t              pv1x;
        wide_t              pv1y;
        wide_t              pt1x;
        wide_t              pt1y;
        wide_t              pv2x;
        wide_t              pv2y;
        wide_t              pt2x;
        wide_t              pt2y;
        wide_t              v1n;
        wide_t              v1t;
        wide_t              v2n;
        wide_t              v2t;
        wide_t              px1;
        wide_t              py1;
        wide_t              px2;
        wide_t              py2;
        logic [33:0]        amag;
        logic               aneg;
        logic [31:0]        msum;
        logic [30:0]        mb;
        logic [65:0]        drem;
        logic [34:0]        q1;
        wide_t              v1a;
        wide_t              v2a;
        wide_t              g1a;
        wide_t              g1b;
        wide_t              g1c;
        wide_t              g1d;
        wide_t              g2a;
        wide_t              g2b;
        wide_t              g2c;
        wide_t              g2d;
    } ctx_t;

    typedef struct packed {
        sfield_t n1px;
        sfield_t n1py;
        sfield_t n1vx;
        sfield_t n1vy;
        sfield_t n2px;
        sfield_t n2py;
        sfield_t n2vx;
        sfield_t n2vy;
        logic    collided;
    } res_t;

endpackage

/* src/edc_front.sv */
module edc_front import edc_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  disc_t in_a,
    input  disc_t in_b,
    output logic  f_valid,
    output pair_t f_item,
    input  logic  f_ready
);

    logic               en;
    logic               v0_reg;
    logic               v1_reg;
    logic               v2_reg;
    pair_t              p0_reg;
    pair_t              p1_reg;
    pair_t              p2_reg;
    pair_t              p0_next;
    pair_t              p2_next;
    logic [63:0]        dx2_reg;
    logic [63:0]        dy2_reg;
    logic [63:0]        md2_reg;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [32:0] ndx;
    logic signed [32:0] ndy;
    logic [64:0]        sum2;

    // Advance the whole front end unless the last stage is stuck
    assign en       = !v2_reg || f_ready;
    assign in_ready = en;
    assign f_valid  = v2_reg;
    assign f_item   = p2_reg;

    // Take centre differences and the contact distance
    always_comb
    begin
        dx  = 33'(in_b.pos_x) - 33'(in_a.pos_x);
        dy  = 33'(in_b.pos_y) - 33'(in_a.pos_y);
        ndx = -dx;
        ndy = -dy;
        p0_next        = '0;
        p0_next.a      = in_a;
        p0_next.b      = in_b;
        p0_next.md     = {1'b0, in_a.radius} + {1'b0, in_b.radius};
        p0_next.adx    = dx[32] ? ndx[31:0] : dx[31:0];
        p0_next.ady    = dy[32] ? ndy[31:0] : dy[31:0];
        p0_next.dx_neg = dx[32];
        p0_next.dy_neg = dy[32];
        p0_next.hit    = (p0_next.adx < p0_next.md) && (p0_next.ady < p0_next.md);
    end

    // Compare the squared distance with the squared contact distance
    always_comb
    begin
        sum2          = {1'b0, dx2_reg} + {1'b0, dy2_reg};
        p2_next       = p1_reg;
        p2_next.dist2 = sum2[63:0];
        p2_next.hit   = p1_reg.hit && (sum2 < {1'b0, md2_reg}) && (sum2 != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    // Square the offsets and the contact distance
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_reg  <= p0_next;
            p1_reg  <= p0_reg;
            dx2_reg <= p0_reg.adx * p0_reg.adx;
            dy2_reg <= p0_reg.ady * p0_reg.ady;
            md2_reg <= p0_reg.md * p0_reg.md;
            p2_reg  <= p2_next;
        end
    end

endmodule

/* src/edc_queue.sv */
module edc_queue import edc_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push_valid,
    output logic  push_ready,
    input  pair_t push_item,
    output logic  pop_valid,
    input  logic  pop_ready,
    output pair_t pop_item
);

    pair_t          mem_reg [QDEPTH];
    logic [QAW-1:0] wp_reg;
    logic [QAW-1:0] rp_reg;
    logic [QAW:0]   cnt_reg;
    logic [QAW:0]   cnt_next;
    logic           push;
    logic           pop;

    assign push_ready = (cnt_reg != QAW'(0) + (QAW+1)'(QDEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_item   = mem_reg[rp_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Track occupancy
    always_comb
    begin
        cnt_next = cnt_reg + (QAW+1)'(push) - (QAW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
                wp_reg <= wp_reg + 1'b1;
            if (pop)
                rp_reg <= rp_reg + 1'b1;
        end
    end

    // Store the incoming request
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= push_item;
    end

endmodule

/* src/edc_back.sv */
module edc_back import edc_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  q_valid,
    output logic  q_ready,
    input  pair_t q_item,
    output logic  out_valid,
    input  logic  out_ready,
    output res_t  out_res
);

    localparam wide_t RND = (64'sd1 <<< FRAC) - 64'sd1;
    localparam wide_t HI  = (64'sd1 <<< (WORD - 1)) - 64'sd1;
    localparam wide_t LO  = -HI - 64'sd1;

    logic  en;
    logic  st_v_reg [NST];
    ctx_t  st_reg   [NST];
    ctx_t  head;
    ctx_t  last;
    logic  out_v_reg;
    res_t  out_reg;
    res_t  out_next;

    // Signed division by 2^FRAC, rounding toward zero
    function automatic wide_t tdiv(wide_t s);
        wide_t t;
        t = s[63] ? s + RND : s;
        return t >>> FRAC;
    endfunction

    function automatic sfield_t sat(wide_t v);
        wide_t t;
        t = v;
        if (t > HI)
            t = HI;
        if (t < LO)
            t = LO;
        return $signed(t[31:0]);
    endfunction

    function automatic logic signed [FRAC+1:0] snorm(logic [FRAC:0] q, logic neg);
        logic signed [FRAC+1:0] t;
        t = $signed({1'b0, q});
        return neg ? -t : t;
    endfunction

    function automatic wide_t smul(sfield_t v, logic signed [FRAC+1:0] n);
        logic signed [FRAC+33:0] pr;
        pr = v * n;
        return wide_t'(pr);
    endfunction

    function automatic wide_t vmul(logic signed [35:0] v, logic signed [FRAC+1:0] n);
        logic signed [FRAC+37:0] pr;
        pr = v * n;
        return wide_t'(pr);
    endfunction

    // One solver stage; k selects which step this stage performs
    function automatic ctx_t stage_fn(ctx_t c, int k);
        ctx_t                   r;
        int                     j;
        logic [63:0]            bitv;
        logic [64:0]            trial;
        logic [FRAC+31:0]       dsh;
        logic [31:0]            half;
        logic signed [FRAC+1:0] nx;
        logic signed [FRAC+1:0] ny;
        wide_t                  a;
        wide_t                  amag;
        wide_t                  sx;
        wide_t                  sy;
        wide_t                  q1w;
        wide_t                  q2w;
        logic [31:0]            ms;
        logic [64:0]            prod;
        logic [65:0]            qsh;
        logic [34:0]            q2;
        r  = c;
        nx = snorm(c.nxq, c.p.dx_neg);
        ny = snorm(c.nyq, c.p.dy_neg);
        if (k < S_DV)
        begin
            // One step of the integer square root
            bitv  = 64'd1 << (62 - 2 * k);
            trial = {1'b0, c.sres} + {1'b0, bitv};
            if ({1'b0, c.srem} >= trial)
            begin
                r.srem = c.srem - trial[63:0];
                r.sres = (c.sres >> 1) + bitv;
            end
            else
            begin
                r.sres = c.sres >> 1;
            end
            if (k == S_DV - 1)
            begin
                r.d    = r.sres[31:0];
                r.xrem = {c.p.adx, {FRAC{1'b0}}};
                r.yrem = {c.p.ady, {FRAC{1'b0}}};
                r.nxq  = '0;
                r.nyq  = '0;
            end
        end
        else if (k < S_M1)
        begin
            // One quotient bit of each normal component
            j   = FRAC - (k - S_DV);
            dsh = (FRAC+32)'(c.d) << j;
            if (c.xrem >= dsh)
            begin
                r.xrem   = c.xrem - dsh;
                r.nxq[j] = 1'b1;
            end
            if (c.yrem >= dsh)
            begin
                r.yrem   = c.yrem - dsh;
                r.nyq[j] = 1'b1;
            end
        end
        else if (k == S_M1)
        begin
            half   = (c.p.md - c.d) >> 1;
            r.hx   = half * c.nxq;
            r.hy   = half * c.nyq;
            r.pv1x = smul(c.p.a.vel_x, nx);
            r.pv1y = smul(c.p.a.vel_y, ny);
            r.pt1x = smul(c.p.a.vel_y, nx);
            r.pt1y = smul(c.p.a.vel_x, ny);
            r.pv2x = smul(c.p.b.vel_x, nx);
            r.pv2y = smul(c.p.b.vel_y, ny);
            r.pt2x = smul(c.p.b.vel_y, nx);
            r.pt2y = smul(c.p.b.vel_x, ny);
        end
        else if (k == S_M2)
        begin
            sx = wide_t'(c.hx >> FRAC);
            sy = wide_t'(c.hy >> FRAC);
            if (c.p.dx_neg)
                sx = -sx;
            if (c.p.dy_neg)
                sy = -sy;
            r.v1n = tdiv(c.pv1x + c.pv1y);
            r.v1t = tdiv(c.pt1x - c.pt1y);
            r.v2n = tdiv(c.pv2x + c.pv2y);
            r.v2t = tdiv(c.pt2x - c.pt2y);
            r.px1 = wide_t'(c.p.a.pos_x) - sx;
            r.py1 = wide_t'(c.p.a.pos_y) - sy;
            r.px2 = wide_t'(c.p.b.pos_x) + sx;
            r.py2 = wide_t'(c.p.b.pos_y) + sy;
        end
        else if (k == S_P1)
        begin
            a      = c.v2n - c.v1n;
            amag   = a[63] ? -a : a;
            r.aneg = a[63];
            r.amag = amag[33:0];
            ms     = {1'b0, c.p.a.mass} + {1'b0, c.p.b.mass};
            // Two massless discs behave as equal unit masses
            if (ms == '0)
            begin
                r.msum = 32'd2;
                r.mb   = 31'd1;
            end
            else
            begin
                r.msum = ms;
                r.mb   = c.p.b.mass;
            end
        end
        else if (k == S_P2)
        begin
            prod   = c.amag * c.mb;
            r.drem = {prod, 1'b0};
            r.q1   = '0;
        end
        else if (k < S_AD)
        begin
            // One quotient bit of the mass ratio
            j   = NQD - 1 - (k - S_QD);
            qsh = 66'(c.msum) << j;
            if (c.drem >= qsh)
            begin
                r.drem  = c.drem - qsh;
                r.q1[j] = 1'b1;
            end
        end
        else if (k == S_AD)
        begin
            // The second ratio is the complement of the first
            q2    = {c.amag, 1'b0} - c.q1 - 35'(c.drem != '0);
            q1w   = wide_t'(c.q1);
            q2w   = wide_t'(q2);
            r.v1a = c.aneg ? c.v1n - q1w : c.v1n + q1w;
            r.v2a = c.aneg ? c.v2n + q2w : c.v2n - q2w;
        end
        else
        begin
            r.g1a = vmul($signed(c.v1a[35:0]), nx);
            r.g1b = vmul($signed(c.v1t[35:0]), ny);
            r.g1c = vmul($signed(c.v1a[35:0]), ny);
            r.g1d = vmul($signed(c.v1t[35:0]), nx);
            r.g2a = vmul($signed(c.v2a[35:0]), nx);
            r.g2b = vmul($signed(c.v2t[35:0]), ny);
            r.g2c = vmul($signed(c.v2a[35:0]), ny);
            r.g2d = vmul($signed(c.v2t[35:0]), nx);
        end
        return r;
    endfunction

    // Stall the whole solver only when the result register is held
    assign en        = !out_v_reg || out_ready;
    assign q_ready   = en;
    assign out_valid = out_v_reg;
    assign out_res   = out_reg;

    always_comb
    begin
        head      = '0;
        head.p    = q_item;
        head.srem = q_item.dist2;
    end

    for (genvar k = 0; k < NST; k++)
    begin : g_st
        ctx_t src;
        ctx_t st_next;
        logic src_v;

        if (k == 0)
        begin : g_head
            assign src   = head;
            assign src_v = q_valid;
        end
        else
        begin : g_tail
            assign src   = st_reg[k-1];
            assign src_v = st_v_reg[k-1];
        end

        assign st_next = stage_fn(src, k);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                st_v_reg[k] <= 1'b0;
            else if (en)
                st_v_reg[k] <= src_v;
        end

        always_ff @(posedge clk)
        begin
            if (en)
                st_reg[k] <= st_next;
        end
    end

    // Rotate back to x and y, saturate, or pass the discs through
    always_comb
    begin
        last = st_reg[NST-1];
        if (last.p.hit)
        begin
            out_next.n1px     = sat(last.px1);
            out_next.n1py     = sat(last.py1);
            out_next.n1vx     = sat(tdiv(last.g1a - last.g1b));
            out_next.n1vy     = sat(tdiv(last.g1c + last.g1d));
            out_next.n2px     = sat(last.px2);
            out_next.n2py     = sat(last.py2);
            out_next.n2vx     = sat(tdiv(last.g2a - last.g2b));
            out_next.n2vy     = sat(tdiv(last.g2c + last.g2d));
            out_next.collided = 1'b1;
        end
        else
        begin
            out_next.n1px     = last.p.a.pos_x;
            out_next.n1py     = last.p.a.pos_y;
            out_next.n1vx     = last.p.a.vel_x;
            out_next.n1vy     = last.p.a.vel_y;
            out_next.n2px     = last.p.b.pos_x;
            out_next.n2py     = last.p.b.pos_y;
            out_next.n2vx     = last.p.b.vel_x;
            out_next.n2vy     = last.p.b.vel_y;
            out_next.collided = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (en)
            out_v_reg <= st_v_reg[NST-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_reg <= out_next;
    end

endmodule

/* src/elastic_disc_collision.sv */
// Elastic collision of two discs, signed Q16.16.
//
// Input channel: in_valid/in_ready carry one request, two discs given by
// position, velocity, radius and mass. Output channel: out_valid/out_ready
// carry one result per request, the updated discs and a collided flag.
// Discs that do not overlap, or whose centres coincide, come back unchanged.
//
// Throughput: one request per cycle when the receiver does not stall. The
// solver runs the 32-step square root, the 17-step normal divider and the
// 35-step mass ratio divider, each one step per pipeline stage.
//
// A classifier front end feeds a four-entry queue, which feeds the solver.
// When out_ready is low with a result waiting, the solver holds; the queue
// then fills and in_ready drops once the front end backs up behind it.
// Reset empties the pipeline and the queue; no result is pending after it.
module elastic_disc_collision import edc_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  sfield_t first_pos_x,
    input  sfield_t first_pos_y,
    input  sfield_t first_vel_x,
    input  sfield_t first_vel_y,
    input  ufield_t first_radius,
    input  ufield_t first_mass,
    input  sfield_t second_pos_x,
    input  sfield_t second_pos_y,
    input  sfield_t second_vel_x,
    input  sfield_t second_vel_y,
    input  ufield_t second_radius,
    input  ufield_t second_mass,
    output logic    out_valid,
    input  logic    out_ready,
    output sfield_t new_first_pos_x,
    output sfield_t new_first_pos_y,
    output sfield_t new_first_vel_x,
    output sfield_t new_first_vel_y,
    output sfield_t new_second_pos_x,
    output sfield_t new_second_pos_y,
    output sfield_t new_second_vel_x,
    output sfield_t new_second_vel_y,
    output logic    collided
);

    disc_t in_a;
    disc_t in_b;
    logic  f_valid;
    logic  f_ready;
    pair_t f_item;
    logic  q_valid;
    logic  q_ready;
    pair_t q_item;
    res_t  res;

    // Gather the port fields
    assign in_a.pos_x  = first_pos_x;
    assign in_a.pos_y  = first_pos_y;
    assign in_a.vel_x  = first_vel_x;
    assign in_a.vel_y  = first_vel_y;
    assign in_a.radius = first_radius;
    assign in_a.mass   = first_mass;
    assign in_b.pos_x  = second_pos_x;
    assign in_b.pos_y  = second_pos_y;
    assign in_b.vel_x  = second_vel_x;
    assign in_b.vel_y  = second_vel_y;
    assign in_b.radius = second_radius;
    assign in_b.mass   = second_mass;

    edc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_a     (in_a),
        .in_b     (in_b),
        .f_valid  (f_valid),
        .f_item   (f_item),
        .f_ready  (f_ready)
    );

    edc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_item  (f_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item)
    );

    edc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (res)
    );

    // Spread the result onto the ports
    assign new_first_pos_x  = res.n1px;
    assign new_first_pos_y  = res.n1py;
    assign new_first_vel_x  = res.n1vx;
    assign new_first_vel_y  = res.n1vy;
    assign new_second_pos_x = res.n2px;
    assign new_second_pos_y = res.n2py;
    assign new_second_vel_x = res.n2vx;
    assign new_second_vel_y = res.n2vy;
    assign collided         = res.collided;

endmodule

/* src/edc_checker.sv */
module edc_props import edc_pkg::*; (
    input logic    clk,
    input logic    rst_n,
    input logic    in_valid,
    input logic    in_ready,
    input logic    out_valid,
    input logic    out_ready,
    input sfield_t new_first_pos_x,
    input sfield_t new_second_vel_y,
    input logic    collided
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(new_first_pos_x)
            && $stable(new_second_vel_y) && $stable(collided))
        else $error("result changed while stalled");

    // Keep both handshake outputs at known levels
    a_known_handshake: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown(in_ready) && !$isunknown(out_valid))
        else $error("handshake output unknown");

    // No result can appear shortly after reset
    a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $past(rst_n, 8))
        else $error("result too soon after reset");

endmodule

bind elastic_disc_collision edc_props u_chk (.*);
